// ----- rtl/ais_pkg.sv -----
`timescale 1ns / 1ps
package ais_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef struct packed {
        logic ins;
        logic pop;
    } t_cell_ctl;

endpackage

// ----- rtl/ais_cell.sv -----
`timescale 1ns / 1ps
module ais_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ais_pkg::t_cell_ctl         i_ctl,
    input  logic [ais_pkg::DATA_W-1:0] i_new,
    input  logic                       i_prev_gt,
    input  logic                       i_prev_valid,
    input  logic [ais_pkg::DATA_W-1:0] i_prev_value,
    input  logic                       i_next_valid,
    input  logic [ais_pkg::DATA_W-1:0] i_next_value,
    output logic                       o_gt,
    output logic                       o_valid,
    output logic [ais_pkg::DATA_W-1:0] o_value
);
    import ais_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_value;

    // an empty cell counts as greater than anything
    assign o_gt    = !r_valid || ($signed(r_value) > $signed(i_new));
    assign o_valid = r_valid;
    assign o_value = r_value;

    // a shifting cell inherits the neighbor's valid bit; the insertion point turns valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.pop) begin
            r_valid <= i_next_valid;
        end else if (i_ctl.ins && o_gt) begin
            r_valid <= i_prev_gt ? i_prev_valid : 1'b1;
        end
    end

    // pop loads the upper word; insert the lower word if it moves up, else the new word
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_value <= i_next_value;
        end else if (i_ctl.ins && o_gt) begin
            r_value <= i_prev_gt ? i_prev_value : i_new;
        end
    end

endmodule

// ----- rtl/ascending_integer_sorter.sv -----
`timescale 1ns / 1ps
// Throughput: one input word per cycle while a set loads; each word is placed into
// a sorted chain of DEPTH cells in the cycle it is accepted; a full chain drops it.
// Drain: the smallest value is offered the cycle after the tlast word is accepted;
// the set drains one word per cycle when m_axis_tready is high, input held off.
// Reset (synchronous, active low) clears the count, the dropped flag and the cell
// valid bits.
module ascending_integer_sorter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [ais_pkg::DATA_W-1:0] s_axis_tdata,   // [31:0] value_in
    input  logic                       s_axis_tlast,   // last_item
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [ais_pkg::DATA_W-1:0] m_axis_tdata,   // [31:0] value_out
    output logic                       m_axis_tlast,   // last_result
    output logic                       m_axis_tuser    // [0] dropped
);
    import ais_pkg::*;

    logic             r_drain;
    logic [CNT_W-1:0] r_count;
    logic             r_ovf;

    logic             w_accept;
    logic             w_full;
    logic             w_pop;
    t_cell_ctl        w_ctl;

    logic              w_gt    [DEPTH];
    logic              w_valid [DEPTH];
    logic [DATA_W-1:0] w_value [DEPTH];

    assign s_axis_tready = !r_drain;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_pop         = r_drain && m_axis_tready;

    assign w_ctl.ins = w_accept && !w_full;
    assign w_ctl.pop = w_pop;

    assign m_axis_tvalid = r_drain;
    assign m_axis_tdata  = w_value[0];
    assign m_axis_tlast  = (r_count == CNT_W'(1));
    assign m_axis_tuser  = r_ovf;

    generate
        for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic              w_pgt;
            logic              w_pvalid;
            logic [DATA_W-1:0] w_pval;
            logic              w_nvalid;
            logic [DATA_W-1:0] w_nval;

            if (gi == 0) begin : g_first
                assign w_pgt    = 1'b0;
                assign w_pvalid = 1'b0;
                assign w_pval   = s_axis_tdata;
            end else begin : g_mid
                assign w_pgt    = w_gt[gi-1];
                assign w_pvalid = w_valid[gi-1];
                assign w_pval   = w_value[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_top
                assign w_nvalid = 1'b0;
                assign w_nval   = w_value[gi];
            end else begin : g_below
                assign w_nvalid = w_valid[gi+1];
                assign w_nval   = w_value[gi+1];
            end

            ais_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_new        (s_axis_tdata),
                .i_prev_gt    (w_pgt),
                .i_prev_valid (w_pvalid),
                .i_prev_value (w_pval),
                .i_next_valid (w_nvalid),
                .i_next_value (w_nval),
                .o_gt         (w_gt[gi]),
                .o_valid      (w_valid[gi]),
                .o_value      (w_value[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= 1'b0;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (r_drain) begin
            if (w_pop) begin
                r_count <= r_count - CNT_W'(1);
                // close the set on the final word
                if (r_count == CNT_W'(1)) begin
                    r_drain <= 1'b0;
                    r_ovf   <= 1'b0;
                end
            end
        end else if (w_accept) begin
            if (w_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
            end
            if (s_axis_tlast) begin
                r_drain <= 1'b1;
            end
        end
    end

endmodule

// ----- bench/sort_checker.sv -----
`timescale 1ns / 1ps
module sort_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    input  logic                       i_s_tready,
    input  logic [ais_pkg::DATA_W-1:0] i_s_tdata,    // [31:0] value_in
    input  logic                       i_s_tlast,    // last_item
    input  logic                       i_m_tvalid,
    input  logic                       i_m_tready,
    input  logic [ais_pkg::DATA_W-1:0] i_m_tdata,    // [31:0] value_out
    input  logic                       i_m_tlast,    // last_result
    input  logic                       i_m_tuser,    // [0] dropped
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_checked
);

    typedef struct packed {
        logic [ais_pkg::DATA_W-1:0] value;
        logic                       last;
        logic                       dropped;
    } t_sorted_word;

    t_sorted_word                      sorted_due[$];
    logic signed [ais_pkg::DATA_W-1:0] set_vals[$];
    logic                              set_overflow;
    t_sorted_word                      head;
    int                                errors;
    int                                checked;

    // Sort the held set in signed order and queue one word per value.
    task automatic queue_sorted();
        logic signed [ais_pkg::DATA_W-1:0] ordered[$];
        logic signed [ais_pkg::DATA_W-1:0] cur;
        t_sorted_word                      w;
        int                                i;
        int                                j;
        ordered = set_vals;
        for (i = 1; i < ordered.size(); i++) begin
            cur = ordered[i];
            j = i;
            while (j > 0 && ordered[j-1] > cur) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = cur;
        end
        for (i = 0; i < ordered.size(); i++) begin
            w.value   = ordered[i];
            w.last    = (i == ordered.size() - 1);
            w.dropped = set_overflow;
            sorted_due.push_back(w);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t ERROR: %s expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sorted_due.delete();
            set_vals.delete();
            set_overflow = 1'b0;
            errors       = 0;
            checked      = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                checked++;
                if (sorted_due.size() == 0) begin
                    $display("%0t ERROR: unexpected word expected none actual %h last %b dropped %b",
                             $time, i_m_tdata, i_m_tlast, i_m_tuser);
                    errors++;
                end else begin
                    head = sorted_due.pop_front();
                    check_field("value", head.value, i_m_tdata);
                    check_field("last", 32'(head.last), 32'(i_m_tlast));
                    check_field("dropped", 32'(head.dropped), 32'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                // Drop the word once the store is full, the closing one too.
                if (set_vals.size() < ais_pkg::DEPTH) begin
                    set_vals.push_back(i_s_tdata);
                end else begin
                    set_overflow = 1'b1;
                end
                if (i_s_tlast) begin
                    queue_sorted();
                    set_vals.delete();
                    set_overflow = 1'b0;
                end
            end
        end
        o_errors  <= errors;
        o_checked <= checked;
        o_pending <= sorted_due.size();
    end

endmodule

// ----- bench/tb_ascending_integer_sorter.sv -----
`timescale 1ns / 1ps
module tb_ascending_integer_sorter;

    localparam logic [31:0] MIN_V = 32'h8000_0000;
    localparam logic [31:0] MAX_V = 32'h7FFF_FFFF;
    localparam int RANDOM_WORDS  = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;

    logic                       i_clk;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [ais_pkg::DATA_W-1:0] s_axis_tdata  = '0;
    logic                       s_axis_tlast  = 1'b0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [ais_pkg::DATA_W-1:0] m_axis_tdata;
    logic                       m_axis_tlast;
    logic                       m_axis_tuser;

    int errors;
    int pending;
    int checked;
    int tx_idle_pct = 26;
    int rx_idle_pct = 49;
    int words_sent  = 0;
    int sets_sent   = 0;
    int full_sets   = 0;
    int idle_run    = 0;

    ascending_integer_sorter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sort_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tlast  (s_axis_tlast),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tlast  (m_axis_tlast),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // End the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_run <= 0;
        end else if (idle_run >= STALL_LIMIT) begin
            $display("%0t timeout: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return MIN_V;
            1:       return MAX_V;
            2, 3:    return 32'($urandom_range(0, 8)) - 32'd4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] value, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic send_set(input logic [31:0] vals[$]);
        int i;
        for (i = 0; i < vals.size(); i++) begin
            send_word(vals[i], i == vals.size() - 1);
        end
        sets_sent++;
        if (vals.size() > ais_pkg::DEPTH) full_sets++;
    endtask

    initial begin
        logic [31:0] set_q[$];
        int          rand_words;
        int          set_len;
        int          big_sets;
        int          i;
        rand_words = 0;
        big_sets   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single value, extremes, duplicates, reverse and ascending order
        set_q = {32'd5};
        send_set(set_q);
        set_q = {MAX_V, MIN_V, 32'd0, 32'hFFFF_FFFF, 32'd1};
        send_set(set_q);
        set_q = {32'd7, 32'd7, 32'hFFFF_FFF9, 32'd7, 32'hFFFF_FFF9};
        send_set(set_q);
        set_q = {32'd3, 32'd2, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE};
        send_set(set_q);
        set_q = {MIN_V, MIN_V + 32'd1, 32'hFFFF_FFFF, 32'd0, MAX_V - 32'd1, MAX_V};
        send_set(set_q);

        while (rand_words < RANDOM_WORDS) begin
            if (rand_words < RANDOM_WORDS / 3) begin
                tx_idle_pct = 26;
                rx_idle_pct = 49;
            end else if (rand_words < 2 * RANDOM_WORDS / 3) begin
                tx_idle_pct = 49;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // Mostly short sets; now and then a near-full or full store or one that overflows.
            if (sets_sent % 8 == 3) begin
                case (big_sets)
                    0:       set_len = ais_pkg::DEPTH;
                    1:       set_len = ais_pkg::DEPTH + 1;
                    default: set_len = $urandom_range(ais_pkg::DEPTH - 1, ais_pkg::DEPTH + 16);
                endcase
                big_sets++;
            end else begin
                set_len = $urandom_range(1, 12);
            end
            set_q.delete();
            for (i = 0; i < set_len; i++) set_q.push_back(pick_value());
            send_set(set_q);
            rand_words += set_len;
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d sets (%0d past capacity); checked %0d sorted words",
                 words_sent, sets_sent, full_sets, checked);
        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ais_pkg.sv
rtl/ais_cell.sv
rtl/ascending_integer_sorter.sv
bench/sort_checker.sv
bench/tb_ascending_integer_sorter.sv
